@@ rtl/t2u64_pkg.sv @@
// ----------------------------------------------------------------------------
// t2u64_pkg
// Types, codes and character helpers for the text to unsigned 64-bit parser.
// ----------------------------------------------------------------------------
package t2u64_pkg;

    // parse phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_WS   = 6'b000010,
        PH_SIGN = 6'b000100,
        PH_ZERO = 6'b001000,
        PH_DIG  = 6'b010000,
        PH_DONE = 6'b100000
    } t_phase;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_OVF    = 2'd1;
    localparam logic [1:0] ST_NOCONV = 2'd2;

    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [5:0] BASE_OCT    = 6'd8;
    localparam logic [5:0] BASE_DEC    = 6'd10;
    localparam logic [5:0] BASE_HEX    = 6'd16;
    localparam logic [5:0] BASE_AUTO   = 6'd0;
    localparam logic [5:0] BASE_MIN    = 6'd2;
    localparam logic [5:0] NOT_DIGIT   = 6'h3F;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;

    // digit value of a character, NOT_DIGIT when it is none
    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'd0;
            if (c >= CH_0 && c <= CH_9) begin
                t = c - CH_0;
            end else if (c >= CH_LA && c <= CH_LZ) begin
                t = c - CH_LA + 8'd10;
            end else if (c >= CH_UA && c <= CH_UZ) begin
                t = c - CH_UA + 8'd10;
            end else begin
                t = {2'b00, NOT_DIGIT};
            end
            digit_of = t[5:0];
        end
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

@@ rtl/text_to_unsigned64_parser.sv @@
// ----------------------------------------------------------------------------
// text_to_unsigned64_parser
// Streaming strtoull-style converter, one character per item.
// ----------------------------------------------------------------------------
// Takes one character per cycle, back to back, except while a character that
// closes a result waits for the previous result to be taken: an accepted
// character is held in the input register, then a single 64x6 multiply-add
// with its overflow check updates the parse state, and a finished result is
// registered in the output register that drives o_out_valid. The input side
// keeps moving while a result waits to be taken, as long as the waiting
// character does not itself close a result. The radix register is latched
// when a string starts; write it only while the block is idle.
module text_to_unsigned64_parser
    import t2u64_pkg::*;
#(
    parameter int MAX_RADIX  = 36,
    parameter int COUNT_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // character channel
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [7:0]   i_char_code,
    input  logic         i_first_of_string,
    input  logic         i_last_of_string,
    // result channel
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [63:0]  o_value,
    output logic [1:0]   o_status,
    output logic [15:0]  o_consumed
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [5:0]            RADIX_TOP = 6'(MAX_RADIX);

    // configuration
    logic [5:0] r_radix;
    logic       cfg_wr;
    logic       cfg_hit;

    // input register
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_first;
    logic       r_last;

    // parse state
    t_phase                r_phase;
    logic                  r_neg;
    logic [5:0]            r_base;
    logic [63:0]           r_acc;
    logic                  r_ovf;
    logic                  r_body;
    logic [COUNT_BITS-1:0] r_cnt;

    t_phase                n_phase;
    logic                  n_neg;
    logic [5:0]            n_base;
    logic [63:0]           n_acc;
    logic                  n_ovf;
    logic                  n_body;
    logic [COUNT_BITS-1:0] n_cnt;

    // result register
    logic        r_out_valid;
    logic [63:0] r_value;
    logic [1:0]  r_status;
    logic [15:0] r_consumed;
    logic [63:0] n_value;
    logic [1:0]  n_status;

    logic        emit;
    logic        advance;
    logic        out_free;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr == 2'b00);
    assign cfg_wr  = psel && penable && pwrite && cfg_hit;
    assign prdata  = cfg_hit ? {26'd0, r_radix} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (cfg_wr) begin
            r_radix <= pwdata[5:0];
        end
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!emit || out_free);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_char  <= i_char_code;
            r_first <= i_first_of_string;
            r_last  <= i_last_of_string;
        end
    end

    // one character of parse work
    always_comb begin
        logic       radix_bad;
        logic       sign_ch;
        logic       x_ch;
        logic       bump;
        logic [5:0] dig;
        logic [5:0] base_d;
        logic [69:0] prod;

        radix_bad = (r_radix == 6'd1) || (r_radix > RADIX_TOP);
        sign_ch   = (r_char == CH_PLUS) || (r_char == CH_MINUS);
        x_ch      = (r_char == CH_LX) || (r_char == CH_UX);
        dig       = digit_of(r_char);
        bump      = 1'b0;
        emit      = 1'b0;
        base_d    = r_base;
        prod      = 70'd0;

        n_phase = r_phase;
        n_neg   = r_neg;
        n_base  = r_base;
        n_acc   = r_acc;
        n_ovf   = r_ovf;
        n_body  = r_body;
        n_cnt   = r_cnt;

        if (r_first) begin
            n_phase = PH_WS;
            n_neg   = 1'b0;
            n_base  = r_radix;
            n_acc   = 64'd0;
            n_ovf   = 1'b0;
            n_body  = 1'b0;
            n_cnt   = '0;
        end

        if (r_first && radix_bad) begin
            emit = 1'b1;
        end else if (n_phase == PH_WS || n_phase == PH_SIGN ||
                     n_phase == PH_ZERO || n_phase == PH_DIG) begin
            priority if (n_phase == PH_WS && is_space(r_char)) begin
                bump = 1'b1;
            end else if (n_phase == PH_WS && sign_ch) begin
                n_neg   = (r_char == CH_MINUS);
                bump    = 1'b1;
                n_phase = PH_SIGN;
            end else if ((n_phase == PH_WS || n_phase == PH_SIGN) && r_char == CH_0 &&
                         (n_base == BASE_AUTO || n_base == BASE_HEX)) begin
                bump    = 1'b1;
                n_body  = 1'b1;
                n_phase = PH_ZERO;
            end else if (n_phase == PH_ZERO && x_ch) begin
                bump    = 1'b1;
                n_base  = BASE_HEX;
                n_body  = 1'b0;
                n_phase = PH_DIG;
            end else begin
                // settle an auto base: octal after a lone zero, else decimal
                if (n_phase != PH_DIG && n_base == BASE_AUTO) begin
                    base_d = (n_phase == PH_ZERO) ? BASE_OCT : BASE_DEC;
                end else begin
                    base_d = n_base;
                end
                n_base  = base_d;
                n_phase = PH_DIG;
                prod    = 70'(n_acc) * 70'(base_d) + 70'(dig);
                if (base_d >= BASE_MIN && dig < base_d) begin
                    if (!n_ovf) begin
                        if (|prod[69:64]) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = prod[63:0];
                        end
                    end
                    n_body = 1'b1;
                    bump   = 1'b1;
                end else begin
                    emit = 1'b1;
                end
            end
            if (r_last) begin
                emit = 1'b1;
            end
        end

        if (bump && n_cnt != COUNT_MAX) begin
            n_cnt = n_cnt + 1'b1;
        end
        if (emit) begin
            n_phase = PH_DONE;
        end
    end

    always_comb begin
        if (!n_body) begin
            n_value  = 64'd0;
            n_status = ST_NOCONV;
        end else if (n_ovf) begin
            n_value  = {64{1'b1}};
            n_status = ST_OVF;
        end else begin
            n_value  = n_neg ? (64'd0 - n_acc) : n_acc;
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_neg   <= 1'b0;
            r_base  <= RADIX_RESET;
            r_acc   <= 64'd0;
            r_ovf   <= 1'b0;
            r_body  <= 1'b0;
            r_cnt   <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_base  <= n_base;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_body  <= n_body;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_value    <= n_value;
            r_status   <= n_status;
            r_consumed <= n_body ? 16'(n_cnt) : 16'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_status    = r_status;
    assign o_consumed  = r_consumed;

`ifndef SYNTH
    a_noconv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_NOCONV) |-> (r_value == 64'd0 && r_consumed == 16'd0))
        else $error("no-conversion result carries a value or count");

    a_ovf_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_OVF) |-> (r_value == {64{1'b1}}))
        else $error("overflow result is not saturated");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_status == ST_OK || r_status == ST_OVF || r_status == ST_NOCONV))
        else $error("undefined status code");

    a_done_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && emit) |=> (r_phase == PH_DONE && r_out_valid))
        else $error("parse did not close after a result");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_char) && $stable(r_phase)))
        else $error("stalled character lost or state moved");
`endif

endmodule
